// ----- design/assert_macros.svh -----
// assert_macros.svh: assertion macros used by the checker file lfu_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

// ----- design/lfu_pkg.sv -----
// lfu_pkg: constants and types for the LFU cache engine.
// No dependencies.
package lfu_pkg;
	localparam int DEPTH      = 64;
	localparam int KEY_BITS   = 16;
	localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS   = $clog2(DEPTH + 1);
	localparam int CAP_BITS   = 7;
	localparam int ADDR_BITS  = 1;
	localparam logic [ADDR_BITS-1:0] REG_CAPACITY = 1'b0;
	localparam logic [CAP_BITS-1:0]  CAP_RESET    = 7'd64;
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;     // latch the incoming word, clear scan results
		logic scan;     // read and compare one slot at rd_cnt_q
		logic commit;   // apply update, build result
	} lfu_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;  // current slot is the last occupied one
		logic empty;      // no occupied slots
	} lfu_stat_t;
endpackage

// ----- design/lfu_if.sv -----
// lfu_if: valid/ready channel interfaces for requests and results.
// No dependencies.
interface lfu_req_if;
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic [15:0]                  key;
	logic signed [31:0]           value;
	modport source (output valid, cmd, key, value, input ready);
	modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface lfu_rsp_if;
	logic               valid;
	logic               ready;
	logic               found;
	logic signed [31:0] read_value;
	logic               evicted;
	logic [15:0]        evicted_key;
	modport source (output valid, found, read_value, evicted, evicted_key, input ready);
	modport sink   (input valid, found, read_value, evicted, evicted_key, output ready);
endinterface

// ----- design/lfu_ctrl.sv -----
// lfu_ctrl: sequencer for load, slot scan and commit of one word.
// Depends on lfu_pkg.
module lfu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  lfu_pkg::lfu_stat_t stat,
	output lfu_pkg::lfu_cmd_t  cmd
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;
	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (stat.empty) state_d = ST_DONE;
				else            state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				// wait until the previous result register is free
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)     out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

// ----- design/lfu_dp.sv -----
// lfu_dp: slot storage, sequential key match and victim search, update.
// Depends on lfu_pkg.
module lfu_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lfu_pkg::lfu_cmd_t                 cmd,
	output lfu_pkg::lfu_stat_t                stat,
	input  logic                              in_cmd,
	input  logic [15:0]                       in_key,
	input  logic [31:0]                       in_value,
	input  logic [lfu_pkg::CAP_BITS-1:0]      capacity,
	output logic                              found,
	output logic [31:0]                       read_value,
	output logic                              evicted,
	output logic [15:0]                       evicted_key
);
	localparam int IB = lfu_pkg::IDX_BITS;
	localparam int CB = lfu_pkg::CNT_BITS;
	localparam int KB = lfu_pkg::KEY_BITS;

	// slot memories (registered read)
	logic [KB-1:0] key_mem   [lfu_pkg::DEPTH];
	logic [31:0]   val_mem   [lfu_pkg::DEPTH];
	logic [31:0]   uses_mem  [lfu_pkg::DEPTH];
	logic [31:0]   stamp_mem [lfu_pkg::DEPTH];

	logic [CB-1:0] occ_q;
	logic [31:0]   stamp_q;
	logic          cmd_q;
	logic [KB-1:0] key_q;
	logic [31:0]   val_q;

	logic [CB-1:0] rd_cnt_q;      // next slot to read
	logic          rd_v_s1;
	logic [IB-1:0] rd_idx_s1;
	logic [KB-1:0] rk_s1;
	logic [31:0]   rv_s1, ru_s1, rs_s1;

	logic          hit_q;
	logic [IB-1:0] hit_idx_q;
	logic [31:0]   hit_val_q, hit_uses_q;
	logic          best_v_q;
	logic [IB-1:0] best_idx_q;
	logic [KB-1:0] best_key_q;
	logic [31:0]   best_uses_q, best_stamp_q;

	logic [CB-1:0] limit;
	logic [CB-1:0] last_cnt;
	logic          rd_issue;

	assign limit = (capacity > lfu_pkg::CAP_BITS'(lfu_pkg::DEPTH))
		? CB'(lfu_pkg::DEPTH) : CB'(capacity);
	assign last_cnt   = occ_q - CB'(1);
	assign stat.empty = (occ_q == '0);
	// read data of the last occupied slot is valid; its results go into hit/best
	assign stat.scan_last = rd_v_s1 && (CB'(rd_idx_s1) == last_cnt);
	// issue reads until the last occupied slot
	assign rd_issue = cmd.scan && ((!rd_v_s1 && rd_cnt_q == '0) ||
		(rd_v_s1 && CB'(rd_idx_s1) != last_cnt && rd_cnt_q <= last_cnt));

	// memory reads: one slot a cycle during scan
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_cnt_q[IB-1:0];
		rk_s1     <= key_mem[rd_cnt_q[IB-1:0]];
		rv_s1     <= val_mem[rd_cnt_q[IB-1:0]];
		ru_s1     <= uses_mem[rd_cnt_q[IB-1:0]];
		rs_s1     <= stamp_mem[rd_cnt_q[IB-1:0]];
	end

	// commit decisions
	logic        do_put, do_ins, do_ev;
	logic [IB-1:0] w_idx;
	logic [31:0] nstamp;
	assign do_put = (cmd_q == lfu_pkg::CMD_PUT) && (limit != '0);
	assign do_ins = do_put && !hit_q;
	assign do_ev  = do_ins && (occ_q >= limit);
	assign w_idx  = hit_q ? hit_idx_q : (do_ev ? best_idx_q : occ_q[IB-1:0]);
	assign nstamp = (stamp_q == 32'hFFFF_FFFF) ? stamp_q : stamp_q + 32'd1;

	// memory writes
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (hit_q && (cmd_q == lfu_pkg::CMD_GET || do_put)) begin
				if (hit_uses_q != 32'hFFFF_FFFF) uses_mem[w_idx] <= hit_uses_q + 32'd1;
				stamp_mem[w_idx] <= nstamp;
				if (do_put) val_mem[w_idx] <= val_q;
			end else if (do_ins) begin
				key_mem[w_idx]   <= key_q;
				val_mem[w_idx]   <= val_q;
				uses_mem[w_idx]  <= 32'd1;
				stamp_mem[w_idx] <= nstamp;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			stamp_q  <= '0;
			rd_cnt_q <= '0;
			rd_v_s1  <= 1'b0;
			hit_q    <= 1'b0;
			best_v_q <= 1'b0;
		end else begin
			rd_v_s1 <= rd_issue && (rd_cnt_q <= last_cnt);
			if (cmd.load) begin
				rd_cnt_q <= '0;
				hit_q    <= 1'b0;
				best_v_q <= 1'b0;
			end
			if (rd_issue) rd_cnt_q <= rd_cnt_q + CB'(1);
			if (rd_v_s1) begin
				if (!hit_q && rk_s1 == key_q) hit_q <= 1'b1;
				if (!best_v_q || ru_s1 < best_uses_q ||
					(ru_s1 == best_uses_q && rs_s1 < best_stamp_q))
					best_v_q <= 1'b1;
			end
			if (cmd.commit) begin
				if ((hit_q && (cmd_q == lfu_pkg::CMD_GET || do_put)) || do_ins)
					stamp_q <= nstamp;
				if (do_ins && !do_ev) occ_q <= occ_q + CB'(1);
			end
		end
	end

	// payload of the loaded word and of scan results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd;
			key_q <= in_key[KB-1:0];
			val_q <= in_value;
		end
		if (rd_v_s1) begin
			if (!hit_q && rk_s1 == key_q) begin
				hit_idx_q  <= rd_idx_s1;
				hit_val_q  <= rv_s1;
				hit_uses_q <= ru_s1;
			end
			if (!best_v_q || ru_s1 < best_uses_q ||
				(ru_s1 == best_uses_q && rs_s1 < best_stamp_q)) begin
				best_idx_q   <= rd_idx_s1;
				best_key_q   <= rk_s1;
				best_uses_q  <= ru_s1;
				best_stamp_q <= rs_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			found       <= hit_q;
			read_value  <= (hit_q && cmd_q == lfu_pkg::CMD_GET) ? hit_val_q : 32'hFFFF_FFFF;
			evicted     <= do_ev;
			evicted_key <= do_ev ? 16'(best_key_q) : 16'd0;
		end
	end
endmodule

// ----- design/lfu_cache_engine.sv -----
// lfu_cache_engine: LFU key-value cache with oldest-access tie-break.
// Each accepted word is loaded, then the occupied slots are scanned one slot
// a cycle for key match and victim search (skipped when empty), then commit
// fills the result register once free; the next word is taken after commit.
// Reset (arst_n, async): occupancy and stamp clear, capacity returns to 64;
// slot contents are left unwritten.
module lfu_cache_engine (
	input  logic        clk,
	input  logic        arst_n,
	lfu_req_if.sink     req,
	lfu_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [lfu_pkg::ADDR_BITS+1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	lfu_pkg::lfu_cmd_t  cmd;
	lfu_pkg::lfu_stat_t stat;
	logic [lfu_pkg::CAP_BITS-1:0] capacity_q;
	logic [31:0] rd_value;

	assign pready = 1'b1;
	assign prdata = (paddr[lfu_pkg::ADDR_BITS+1:2] == lfu_pkg::REG_CAPACITY)
		? 32'(capacity_q) : 32'd0;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) capacity_q <= lfu_pkg::CAP_RESET;
		else if (psel && penable && pwrite &&
			paddr[lfu_pkg::ADDR_BITS+1:2] == lfu_pkg::REG_CAPACITY)
			capacity_q <= pwdata[lfu_pkg::CAP_BITS-1:0];
	end

	lfu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .stat(stat), .cmd(cmd)
	);

	lfu_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_cmd(req.cmd), .in_key(req.key), .in_value(req.value),
		.capacity(capacity_q), .found(rsp.found), .read_value(rd_value),
		.evicted(rsp.evicted), .evicted_key(rsp.evicted_key)
	);
	assign rsp.read_value = rd_value;
endmodule

// ----- design/lfu_checker.sv -----
// lfu_checker: port-level checks for lfu_cache_engine, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module lfu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [31:0] read_value,
	input logic        evicted,
	input logic [15:0] evicted_key
);
	// no new word taken in the cycle after one is accepted
	`CHK_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready)
	// a stalled result holds
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(found))
	// eviction only on a miss
	`CHK_IMPL(a_ev_miss, clk, arst_n, out_valid && evicted, !found)
	// no eviction reports zero key
	`CHK_IMPL(a_ev_key, clk, arst_n, out_valid && !evicted, evicted_key == 16'd0)
	// a miss reads back all ones
	`CHK_IMPL(a_miss_val, clk, arst_n, out_valid && !found, read_value == 32'hFFFF_FFFF)
endmodule

bind lfu_cache_engine lfu_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready), .found(rsp.found),
	.read_value(rsp.read_value), .evicted(rsp.evicted), .evicted_key(rsp.evicted_key)
);
